/* sv/olis_pkg.sv */
// ---------------------------------------------------------------------------
// olis_pkg
// shared codes and constants of the ordered list with insert and search
// ---------------------------------------------------------------------------
package olis_pkg;

  localparam int DEPTH_DEF   = 64;  // default list capacity
  localparam int MAX_RESULTS = 64;  // cap on results of one search-all
  localparam int OPCODE_W    = 3;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 7;
  localparam int STATUS_W    = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_HEAD     = 3'd0,
    OP_INS_TAIL     = 3'd1,
    OP_INS_POS      = 3'd2,
    OP_SEARCH_FIRST = 3'd3,
    OP_SEARCH_ALL   = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FOUND     = 2'd3
  } status_t;

endpackage

/* sv/olis_ram.sv */
// ---------------------------------------------------------------------------
// olis_ram
// simple dual-port ram: one write port, one read port with registered data
// ---------------------------------------------------------------------------
module olis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ordered_list_insert_search.sv */
// ---------------------------------------------------------------------------
// ordered_list_insert_search
// ordered list of signed 32-bit values with positional insert and search
// ---------------------------------------------------------------------------
// The list lives in one DEPTH x 32 ram with a registered read; only
// the entry count is cleared by reset, so no clearing pass is needed. Each
// input beat carries an opcode: insert at head, insert at tail, insert at a
// 1-based position (0 or 1 means head, past the end means tail), search for
// the first match, or search for all matches. The block takes one input beat
// at a time. An insert moves the entries at and after the target down one
// place, one entry per cycle through the ram (read one entry, write it back
// one slot lower while the next one is read), then writes the new value.
// A search streams the entries through the read port and compares one per
// cycle while the output side does not stall it. An insert into a full
// list is dropped and answered with a list-full status. Search-all answers
// one beat per match in list order, the final one marked last, at most 64
// beats; with no match it answers a single not-found beat. Opcodes 5 to 7
// are taken and answered with nothing. Results sit in an output register,
// so the next input beat is taken while a finished result still waits.
// ---------------------------------------------------------------------------
module ordered_list_insert_search
  import olis_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic [POS_W-1:0]    insert_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [POS_W-1:0]    match_position,
  output logic [POS_W-1:0]    list_length,
  output logic                last_result
);

  localparam int AW = $clog2(DEPTH);         // ram address
  localparam int CW = $clog2(DEPTH + 1);     // count, 0..DEPTH
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;  // position compare
  localparam int NW = $clog2(MAX_RESULTS);   // matches held so far
  localparam logic [NW-1:0] N_CAP = NW'(MAX_RESULTS - 1);

  // one-hot control states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SHIFT  = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;

  // list length
  logic [CW-1:0] count, count_next;

  // working registers of the current item
  logic [VALUE_W-1:0] val, val_next;          // value to insert or to match
  logic               op_first, op_first_next; // search stops at first match
  logic [CW-1:0]      ptr, ptr_next;          // next ram address to read
  logic [AW-1:0]      ins_idx, ins_idx_next;  // 0-based insert slot

  // shift pipeline: entry read last cycle is written one slot lower
  logic               reads_done, reads_done_next;
  logic               wb_valid, wb_valid_next;
  logic [AW-1:0]      wb_addr, wb_addr_next;

  // search pipeline: ram data of cmp_ptr is ready for compare
  logic               cmp_valid, cmp_valid_next;
  logic [CW-1:0]      cmp_ptr, cmp_ptr_next;

  // search-all holds its newest match back until it knows if it is the last
  logic               hold_valid, hold_valid_next;
  logic [POS_W-1:0]   hold_pos, hold_pos_next;
  logic [NW-1:0]      n_held, n_held_next;

  // final response of the item, sent from S_DONE
  status_t            resp_status, resp_status_next;
  logic [POS_W-1:0]   resp_pos, resp_pos_next;

  // output register
  logic               out_valid_next;
  status_t            out_status, out_status_next;
  logic [POS_W-1:0]   out_pos, out_pos_next;
  logic [POS_W-1:0]   out_len, out_len_next;
  logic               out_last, out_last_next;

  // ram ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // helpers
  logic               slot_free;
  logic               full;
  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      cnt_x;
  logic [CW-1:0]      idx_sel;
  logic               match;
  logic               stall;
  logic               issue;
  logic [POS_W-1:0]   cmp_pos;

  olis_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready       = (state == S_IDLE);
  assign status         = out_status;
  assign match_position = out_pos;
  assign list_length    = out_len;
  assign last_result    = out_last;

  assign slot_free = !out_valid || out_ready;
  assign full      = (count == CW'(DEPTH));

  // target slot of an insert, clamped to head and tail
  always_comb begin
    pos_x = XW'(insert_position);
    cnt_x = XW'(count);
    case (opcode_t'(opcode))
      OP_INS_HEAD: idx_sel = '0;
      OP_INS_TAIL: idx_sel = count;
      OP_INS_POS: begin
        if (pos_x <= XW'(1)) begin
          idx_sel = '0;
        end else if (pos_x - XW'(1) > cnt_x) begin
          idx_sel = count;
        end else begin
          idx_sel = CW'(pos_x - XW'(1));
        end
      end
      default: idx_sel = '0;
    endcase
  end

  // search compare on the registered ram data
  assign match   = cmp_valid && (ram_rdata == val);
  assign stall   = match && hold_valid && !slot_free;
  assign issue   = (ptr < count);
  assign cmp_pos = POS_W'(cmp_ptr + 1'b1);

  always_comb begin
    state_next       = state;
    count_next       = count;
    val_next         = val;
    op_first_next    = op_first;
    ptr_next         = ptr;
    ins_idx_next     = ins_idx;
    reads_done_next  = reads_done;
    wb_valid_next    = wb_valid;
    wb_addr_next     = wb_addr;
    cmp_valid_next   = cmp_valid;
    cmp_ptr_next     = cmp_ptr;
    hold_valid_next  = hold_valid;
    hold_pos_next    = hold_pos;
    n_held_next      = n_held;
    resp_status_next = resp_status;
    resp_pos_next    = resp_pos;

    out_valid_next   = out_valid && !out_ready;
    out_status_next  = out_status;
    out_pos_next     = out_pos;
    out_len_next     = out_len;
    out_last_next    = out_last;

    ram_we    = 1'b0;
    ram_waddr = wb_addr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (opcode_t'(opcode)) inside
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
              if (full) begin
                // insert dropped, list untouched
                resp_status_next = ST_FULL;
                resp_pos_next    = '0;
                state_next       = S_DONE;
              end else begin
                val_next        = item_value;
                ins_idx_next    = idx_sel[AW-1:0];
                ptr_next        = count - 1'b1;
                reads_done_next = (idx_sel == count);
                wb_valid_next   = 1'b0;
                state_next      = S_SHIFT;
              end
            end
            OP_SEARCH_FIRST, OP_SEARCH_ALL: begin
              val_next        = item_value;
              op_first_next   = (opcode_t'(opcode) == OP_SEARCH_FIRST);
              ptr_next        = '0;
              cmp_valid_next  = 1'b0;
              hold_valid_next = 1'b0;
              n_held_next     = '0;
              state_next      = S_SEARCH;
            end
            default: begin
              // unused opcode: no effect, no result
            end
          endcase
        end
      end

      S_SHIFT: begin
        if (wb_valid) begin
          // move the entry read last cycle one slot down
          ram_we        = 1'b1;
          ram_waddr     = wb_addr;
          ram_wdata     = ram_rdata;
          wb_valid_next = 1'b0;
        end else if (reads_done) begin
          // all later entries moved, drop the new value in
          ram_we           = 1'b1;
          ram_waddr        = ins_idx;
          ram_wdata        = val;
          count_next       = count + 1'b1;
          resp_status_next = ST_INSERTED;
          resp_pos_next    = '0;
          state_next       = S_DONE;
        end
        if (!reads_done) begin
          ram_re        = 1'b1;
          ram_raddr     = ptr[AW-1:0];
          wb_valid_next = 1'b1;
          wb_addr_next  = ptr[AW-1:0] + 1'b1;
          if (ptr[AW-1:0] == ins_idx) begin
            reads_done_next = 1'b1;
          end else begin
            ptr_next = ptr - 1'b1;
          end
        end
      end

      S_SEARCH: begin
        if (!stall) begin
          if (issue) begin
            ram_re    = 1'b1;
            ram_raddr = ptr[AW-1:0];
            ptr_next  = ptr + 1'b1;
          end
          cmp_valid_next = issue;
          cmp_ptr_next   = ptr;
          if (match) begin
            if (hold_valid) begin
              // a later match exists, so the held one is not last
              out_valid_next  = 1'b1;
              out_status_next = ST_FOUND;
              out_pos_next    = hold_pos;
              out_len_next    = POS_W'(count);
              out_last_next   = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_pos_next   = cmp_pos;
            n_held_next     = n_held + 1'b1;
            if (op_first || n_held == N_CAP) begin
              // first match wanted, or result cap reached
              resp_status_next = ST_FOUND;
              resp_pos_next    = cmp_pos;
              cmp_valid_next   = 1'b0;
              state_next       = S_DONE;
            end
          end else if (!cmp_valid && !issue) begin
            // whole list compared
            resp_status_next = hold_valid ? ST_FOUND : ST_NOT_FOUND;
            resp_pos_next    = hold_valid ? hold_pos : '0;
            state_next       = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_status_next = resp_status;
          out_pos_next    = resp_pos;
          out_len_next    = POS_W'(count);
          out_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      wb_valid   <= 1'b0;
      cmp_valid  <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      wb_valid   <= wb_valid_next;
      cmp_valid  <= cmp_valid_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    val         <= val_next;
    op_first    <= op_first_next;
    ptr         <= ptr_next;
    ins_idx     <= ins_idx_next;
    reads_done  <= reads_done_next;
    wb_addr     <= wb_addr_next;
    cmp_ptr     <= cmp_ptr_next;
    hold_pos    <= hold_pos_next;
    n_held      <= n_held_next;
    resp_status <= resp_status_next;
    resp_pos    <= resp_pos_next;
    out_status  <= out_status_next;
    out_pos     <= out_pos_next;
    out_len     <= out_len_next;
    out_last    <= out_last_next;
  end

  // list never grows past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("list count beyond capacity");

  // count only ever grows by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + 1'b1))
    else $error("list count changed by other than one");

  // shift pipeline never reads and writes the same entry at once
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write hit the same entry");

  // moved entries only land below the insert slot
  a_shift_above: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && wb_valid) |-> (wb_addr > ins_idx))
    else $error("shift writes at or above the insert slot");

endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the ordered list with positional insert and search
// ---------------------------------------------------------------------------
// A shadow copy of the list is kept in the bench and updated at every accepted
// input beat. The bench works out from it the result beats that the beat must
// give and queues them. Every result beat taken from the block is compared
// field by field with the oldest queued one. A short table of directed beats
// comes first. Rows whose answer is obvious carry it typed in, and the rest
// are checked through the shadow list. Random beats follow. Most of them are
// inserts and searches whose values come from a small pool or from the list
// itself, so that matches and duplicates are common. The list fills up part
// way through the run, and the later inserts then hit the full list. The
// sender works in bursts with gaps, the receiver stalls on modes of its own,
// and the sender three times holds off until every queued result has arrived.
// ---------------------------------------------------------------------------
module tb_top
  import olis_pkg::*;
();

  localparam int RANDOM_ITEMS  = 410;
  localparam int DIRECTED_N    = 25;
  localparam int DRAIN_LIMIT   = 200000;  // cycles allowed for the last results
  localparam int LATENCY_TAIL  = DEPTH_DEF + 32;

  // opcodes the block takes and ignores
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI  = 3'd7;

  typedef struct {
    status_t          st;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic             last;
  } list_result_t;

  typedef struct {
    logic [OPCODE_W-1:0]       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    bit                        typed;  // answer typed in below
    status_t                   want_st;
    logic [POS_W-1:0]          want_len;
  } list_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_t;

  // clock, reset and block inputs, all known from time zero
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic [OPCODE_W-1:0]       opcode = '0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic [POS_W-1:0]          insert_position = '0;
  logic                      out_ready = 1'b0;

  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    match_position;
  logic [POS_W-1:0]    list_length;
  logic                last_result;

  // shadow of the list and the result beats still owed by the block
  logic signed [VALUE_W-1:0] shadow_list [DEPTH_DEF];
  int                        shadow_len = 0;
  list_result_t              step_results [$];
  list_result_t              results_due [$];

  int       mismatch_count = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold = 0;

  // directed beats; list contents noted after each insert
  list_row_t directed_rows [DIRECTED_N] = '{
    // empty list: both searches miss
    '{OP_SEARCH_FIRST, 32'sd5,            7'd0,   1'b1, ST_NOT_FOUND, 7'd0},
    '{OP_SEARCH_ALL,   32'sd5,            7'd0,   1'b1, ST_NOT_FOUND, 7'd0},
    // [max]
    '{OP_INS_HEAD,     32'sh7FFFFFFF,     7'd0,   1'b1, ST_INSERTED,  7'd1},
    // [max min]
    '{OP_INS_TAIL,     32'sh80000000,     7'd0,   1'b1, ST_INSERTED,  7'd2},
    // position zero goes to the head: [-1 max min]
    '{OP_INS_POS,      -32'sd1,           7'd0,   1'b1, ST_INSERTED,  7'd3},
    // position one goes to the head: [0 -1 max min]
    '{OP_INS_POS,      32'sd0,            7'd1,   1'b1, ST_INSERTED,  7'd4},
    // far past the end goes to the tail: [0 -1 max min 5]
    '{OP_INS_POS,      32'sd5,            7'd127, 1'b1, ST_INSERTED,  7'd5},
    // middle: [0 -1 -1 max min 5]
    '{OP_INS_POS,      -32'sd1,           7'd3,   1'b1, ST_INSERTED,  7'd6},
    // exactly one past the end: [0 -1 -1 max min 5 9]
    '{OP_INS_POS,      32'sd9,            7'd7,   1'b1, ST_INSERTED,  7'd7},
    // position equal to the capacity, past the end: [0 -1 -1 max min 5 9 3]
    '{OP_INS_POS,      32'sd3,            7'd64,  1'b1, ST_INSERTED,  7'd8},
    '{OP_SEARCH_FIRST, -32'sd1,           7'd0,   1'b0, ST_FOUND,     7'd0},
    '{OP_SEARCH_ALL,   -32'sd1,           7'd0,   1'b0, ST_FOUND,     7'd0},
    '{OP_SEARCH_FIRST, 32'sh80000000,     7'd0,   1'b0, ST_FOUND,     7'd0},
    '{OP_SEARCH_ALL,   32'sh7FFFFFFF,     7'd0,   1'b0, ST_FOUND,     7'd0},
    '{OP_SEARCH_FIRST, 32'sd3,            7'd0,   1'b0, ST_FOUND,     7'd0},
    '{OP_SEARCH_ALL,   32'sd0,            7'd0,   1'b0, ST_FOUND,     7'd0},
    '{OP_SEARCH_ALL,   32'sd12345,        7'd0,   1'b1, ST_NOT_FOUND, 7'd8},
    '{OP_SEARCH_FIRST, 32'sh12345678,     7'd0,   1'b1, ST_NOT_FOUND, 7'd8},
    // unused opcodes answer nothing
    '{OP_UNUSED_LO,    32'sd0,            7'd0,   1'b0, ST_FOUND,     7'd0},
    '{OP_UNUSED_MID,   -32'sd1,           7'd127, 1'b0, ST_FOUND,     7'd0},
    '{OP_UNUSED_HI,    32'sh7FFFFFFF,     7'd64,  1'b0, ST_FOUND,     7'd0},
    // just before the last entry: [0 -1 -1 max min 5 9 42 3]
    '{OP_INS_POS,      32'sd42,           7'd8,   1'b1, ST_INSERTED,  7'd9},
    '{OP_SEARCH_ALL,   32'sd42,           7'd0,   1'b0, ST_FOUND,     7'd0},
    '{OP_INS_TAIL,     -32'sd1,           7'd0,   1'b1, ST_INSERTED,  7'd10},
    // three matches in a row of results
    '{OP_SEARCH_ALL,   -32'sd1,           7'd0,   1'b0, ST_FOUND,     7'd0}
  };

  ordered_list_insert_search u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .item_value      (item_value),
    .insert_position (insert_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .match_position  (match_position),
    .list_length     (list_length),
    .last_result     (last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one line per mismatch, and count it
  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // apply one beat to the shadow list and collect the result beats it owes
  task automatic shadow_step(input logic [OPCODE_W-1:0] op,
                             input logic signed [VALUE_W-1:0] val,
                             input logic [POS_W-1:0] pos);
    int           idx;
    list_result_t r;
    step_results.delete();
    case (op) inside
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
        if (shadow_len >= DEPTH_DEF) begin
          // full list: insert dropped
          step_results.push_back('{ST_FULL, POS_W'(0), POS_W'(shadow_len), 1'b1});
        end else begin
          if (op == OP_INS_HEAD) begin
            idx = 0;
          end else if (op == OP_INS_TAIL) begin
            idx = shadow_len;
          end else if (pos <= 1) begin
            idx = 0;
          end else if (int'(pos) - 1 > shadow_len) begin
            idx = shadow_len;
          end else begin
            idx = int'(pos) - 1;
          end
          for (int i = shadow_len; i > idx; i--) begin
            shadow_list[i] = shadow_list[i-1];
          end
          shadow_list[idx] = val;
          shadow_len++;
          step_results.push_back('{ST_INSERTED, POS_W'(0), POS_W'(shadow_len), 1'b1});
        end
      end
      OP_SEARCH_FIRST: begin
        idx = -1;
        for (int i = 0; i < shadow_len && idx < 0; i++) begin
          if (shadow_list[i] == val) idx = i;
        end
        if (idx < 0) begin
          step_results.push_back('{ST_NOT_FOUND, POS_W'(0), POS_W'(shadow_len), 1'b1});
        end else begin
          step_results.push_back('{ST_FOUND, POS_W'(idx + 1), POS_W'(shadow_len), 1'b1});
        end
      end
      OP_SEARCH_ALL: begin
        for (int i = 0; i < shadow_len && step_results.size() < MAX_RESULTS; i++) begin
          if (shadow_list[i] == val) begin
            step_results.push_back('{ST_FOUND, POS_W'(i + 1), POS_W'(shadow_len), 1'b0});
          end
        end
        if (step_results.size() == 0) begin
          step_results.push_back('{ST_NOT_FOUND, POS_W'(0), POS_W'(shadow_len), 1'b1});
        end else begin
          // mark the final match
          r = step_results.pop_back();
          r.last = 1'b1;
          step_results.push_back(r);
        end
      end
      default: begin
        // unused opcodes leave the list alone and answer nothing
      end
    endcase
  endtask

  // present one beat, hold it until taken, then queue what it owes
  task automatic send_beat(input logic [OPCODE_W-1:0] op,
                           input logic signed [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos,
                           input bit typed,
                           input list_result_t typed_res);
    in_valid        <= 1'b1;
    opcode          <= op;
    item_value      <= val;
    insert_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow_step(op, val, pos);
    if (typed) begin
      results_due.push_back(typed_res);
    end else begin
      foreach (step_results[k]) results_due.push_back(step_results[k]);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 3);
    if (r < 85) return $urandom_range(4, 20);
    return $urandom_range(21, 90);  // the longest gaps, some longer than a full walk of the list
  endfunction

  // sender pacing after each taken beat: keep going, take a gap, or drain
  task automatic pace_sender(input bit drain);
    if (drain) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (results_due.size() != 0) @(posedge clk);
    end else if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
      // now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // values from a small pool, from the list itself, or anything at all
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      case ($urandom_range(0, 7))
        0:       return 32'sd0;
        1:       return -32'sd1;
        2:       return 32'sd1;
        3:       return 32'sh80000000;
        4:       return 32'sh7FFFFFFF;
        5:       return 32'sd7;
        6:       return 32'sh55555555;
        default: return 32'shAAAAAAAA;
      endcase
    end
    if (r < 70 && shadow_len > 0) return shadow_list[$urandom_range(0, shadow_len - 1)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return POS_W'($urandom_range(0, shadow_len + 1));
    if (r < 50) begin
      case ($urandom_range(0, 5))
        0:       return POS_W'(0);
        1:       return POS_W'(1);
        2:       return POS_W'(shadow_len);
        3:       return POS_W'(shadow_len + 1);
        4:       return POS_W'(DEPTH_DEF);
        default: return '1;
      endcase
    end
    return POS_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_opcode(input int n);
    int r;
    // the list has to be full before the end so that dropped inserts are seen
    if (n >= RANDOM_ITEMS - 80 && shadow_len < DEPTH_DEF) begin
      return OPCODE_W'($urandom_range(OP_INS_HEAD, OP_INS_POS));
    end
    r = $urandom_range(0, 99);
    if (r < 12) return OP_INS_HEAD;
    if (r < 22) return OP_INS_TAIL;
    if (r < 34) return OP_INS_POS;
    if (r < 62) return OP_SEARCH_FIRST;
    if (r < 95) return OP_SEARCH_ALL;
    return OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  // receiver: open, coin-flip, or mostly open with stall runs
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(RX_OPEN, RX_CHOKE));
      rx_mode_left <= $urandom_range(50, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_hold != 0) begin
          out_ready <= 1'b0;
          rx_hold   <= rx_hold - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          out_ready <= 1'b0;
          rx_hold   <= $urandom_range(1, 16);
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // compare a taken result beat with the oldest owed one
  task automatic check_beat();
    list_result_t want;
    if (results_due.size() == 0) begin
      flag_mismatch($sformatf("result beat with nothing owed, status %0d pos %0d len %0d",
                              status, match_position, list_length));
      return;
    end
    want = results_due.pop_front();
    if (status !== want.st) begin
      flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
    end
    if (match_position !== want.pos) begin
      flag_mismatch($sformatf("match_position %0d, want %0d", match_position, want.pos));
    end
    if (list_length !== want.len) begin
      flag_mismatch($sformatf("list_length %0d, want %0d", list_length, want.len));
    end
    if (last_result !== want.last) begin
      flag_mismatch($sformatf("last_result %0b, want %0b", last_result, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) check_beat();
  end

  initial begin
    logic [OPCODE_W-1:0]       op;
    logic signed [VALUE_W-1:0] val;
    logic [POS_W-1:0]          pos;
    list_result_t              no_typed;
    int                        waited;

    no_typed = '{ST_INSERTED, POS_W'(0), POS_W'(0), 1'b0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 12);

    // directed table; hold off after the last row until all answers are in
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
                directed_rows[i].typed,
                '{directed_rows[i].want_st, POS_W'(0), directed_rows[i].want_len, 1'b1});
      pace_sender(i == DIRECTED_N - 1);
    end

    // random beats, with two more hold-offs along the way
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      op  = pick_opcode(n);
      val = pick_value();
      pos = pick_position();
      send_beat(op, val, pos, 1'b0, no_typed);
      if (n != RANDOM_ITEMS - 1) pace_sender(n == 140 || n == 290);
    end
    in_valid <= 1'b0;

    // wait for the owed results, then give the block time to show strays
    waited = 0;
    while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY_TAIL) @(posedge clk);
    if (results_due.size() != 0) begin
      flag_mismatch($sformatf("%0d result beats never arrived", results_due.size()));
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #30000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
